>>> sv/upd_pkg.sv
// shared types and constants for the url percent decoder with utf-8 check
// used by the front, queue, back end and top modules; depends on nothing
`default_nettype none

package upd_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_PCT  = 3'b010,
    PH_HEX  = 3'b100
  } upd_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_zero;
    logic       is_pct;
    logic       is_plus;
    logic       hex_ok;
    logic [3:0] hex_val;
  } upd_item_t;

endpackage

`default_nettype wire

>>> sv/upd_fifo.sv
// short queue of classified characters between front and back
// depends on upd_pkg
`default_nettype none

module upd_fifo import upd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire upd_item_t push_item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output upd_item_t      pop_item_o,
  output logic           valid_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  upd_item_t      mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/upd_front.sv
// input side: takes url characters and classifies them (hex digit, percent, plus, zero)
// depends on upd_pkg
`default_nettype none

module upd_front import upd_pkg::*; (
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // char_in
  input  wire logic       s_axis_tlast,   // last_char
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output upd_item_t       q_item_o
);

  logic [7:0] c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o         = '0;
    q_item_o.ch      = c;
    q_item_o.last    = s_axis_tlast;
    q_item_o.is_zero = (c == 8'h00);
    q_item_o.is_pct  = (c == CharPct);
    q_item_o.is_plus = (c == CharPlus);
    if (c >= 8'h30 && c <= 8'h39) begin
      q_item_o.hex_ok  = 1'b1;
      q_item_o.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      q_item_o.hex_ok  = 1'b1;
      q_item_o.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

`default_nettype wire

>>> sv/upd_back.sv
// back end: escape decoding, percent-group tracking, utf-8 validation, result register
// depends on upd_pkg
`default_nettype none

module upd_back import upd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire upd_item_t  q_item_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [1:0]      m_axis_tuser,   // byte_valid, decode_ok
  output logic            m_axis_tlast    // done_res
);

  upd_phase_e phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic [2:0] groups_q, groups_d;
  logic [1:0] uleft_q, uleft_d;
  logic [7:0] ulead_q, ulead_d;
  logic [1:0] upos_q, upos_d;
  logic [7:0] usec_q, usec_d;
  logic       failed_q, failed_d;

  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic [1:0] ouser_q, ouser_d;
  logic       olast_q, olast_d;

  logic       emit, dec_ok, utf_ok, produce, pop;
  logic [7:0] b, v;

  assign pop     = q_valid_i && (!ovalid_q || m_axis_tready);
  assign q_pop_o = pop;

  always_comb begin
    phase_d  = phase_q;
    nib_d    = nib_q;
    groups_d = groups_q;
    uleft_d  = uleft_q;
    ulead_d  = ulead_q;
    upos_d   = upos_q;
    usec_d   = usec_q;
    failed_d = failed_q;
    emit     = 1'b0;
    b        = 8'h00;
    v        = {nib_q, q_item_i.hex_val};
    dec_ok   = 1'b0;
    utf_ok   = 1'b1;

    if (!failed_q) begin
      unique case (phase_q)
        PH_TEXT: begin
          if (q_item_i.is_zero) begin
            failed_d = 1'b1;
          end else if (q_item_i.is_pct) begin
            phase_d = PH_PCT;
          end else if (groups_q != 3'd0) begin
            failed_d = 1'b1;
          end else begin
            b    = q_item_i.is_plus ? CharSpace : q_item_i.ch;
            emit = 1'b1;
          end
        end
        PH_PCT: begin
          if (!q_item_i.hex_ok) begin
            failed_d = 1'b1;
          end else begin
            nib_d   = q_item_i.hex_val;
            phase_d = PH_HEX;
          end
        end
        default: begin
          phase_d = PH_TEXT;
          if (!q_item_i.hex_ok) begin
            failed_d = 1'b1;
          end else begin
            b = v;
            if (groups_q != 3'd0) begin
              dec_ok = (v[7:6] == 2'b10);
              if (dec_ok) groups_d = groups_q - 3'd1;
            end else if (v[7]) begin
              if (v[7:6] != 2'b11) begin
                dec_ok = 1'b0;
              end else if (!v[5]) begin
                dec_ok = 1'b1; groups_d = 3'd1;
              end else if (!v[4]) begin
                dec_ok = 1'b1; groups_d = 3'd2;
              end else if (!v[3]) begin
                dec_ok = 1'b1; groups_d = 3'd3;
              end
            end else begin
              dec_ok = (v >= 8'h20) && (v < 8'h7f);
            end
            if (dec_ok) emit = 1'b1;
            else failed_d = 1'b1;
          end
        end
      endcase

      if (emit) begin
        if (uleft_q == 2'd0) begin
          if (b[7]) begin
            priority if (b[7:5] == 3'b110) begin
              if (b[7:1] == 7'b1100000) utf_ok = 1'b0;
              else uleft_d = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              uleft_d = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
              if (b > 8'hf4) utf_ok = 1'b0;
              else uleft_d = 2'd3;
            end else begin
              utf_ok = 1'b0;
            end
            if (utf_ok) begin
              ulead_d = b;
              upos_d  = 2'd1;
            end
          end
        end else begin
          if (b[7:6] != 2'b10) begin
            utf_ok = 1'b0;
          end else if (upos_q == 2'd1) begin
            if ((ulead_q == 8'he0 && b[7:5] == 3'b100) ||
                (ulead_q == 8'hed && b[7:5] == 3'b101) ||
                (ulead_q == 8'hf0 && b[7:4] == 4'b1000) ||
                (ulead_q == 8'hf4 && b > 8'h8f)) begin
              utf_ok = 1'b0;
            end else begin
              usec_d = b;
            end
          end else if (upos_q == 2'd2) begin
            if (ulead_q == 8'hef && usec_q == 8'hbf && b[7:1] == 7'b1011111) begin
              utf_ok = 1'b0;
            end
          end
          if (utf_ok) begin
            uleft_d = uleft_q - 2'd1;
            upos_d  = upos_q + 2'd1;
          end
        end
        if (!utf_ok) begin
          failed_d = 1'b1;
          emit     = 1'b0;
        end
      end
    end

    produce = emit || q_item_i.last;
    obyte_d = emit ? b : 8'h00;
    olast_d = q_item_i.last;
    ouser_d = {q_item_i.last && !failed_d && phase_d == PH_TEXT &&
               groups_d == 3'd0 && uleft_d == 2'd0, emit};

    if (q_item_i.last) begin
      phase_d  = PH_TEXT;
      nib_d    = '0;
      groups_d = '0;
      uleft_d  = '0;
      ulead_d  = '0;
      upos_d   = '0;
      usec_d   = '0;
      failed_d = 1'b0;
    end

    if (pop) ovalid_d = produce;
    else if (m_axis_tready) ovalid_d = 1'b0;
    else ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TEXT;
      nib_q    <= '0;
      groups_q <= '0;
      uleft_q  <= '0;
      ulead_q  <= '0;
      upos_q   <= '0;
      usec_q   <= '0;
      failed_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (pop) begin
        phase_q  <= phase_d;
        nib_q    <= nib_d;
        groups_q <= groups_d;
        uleft_q  <= uleft_d;
        ulead_q  <= ulead_d;
        upos_q   <= upos_d;
        usec_q   <= usec_d;
        failed_q <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && produce) begin
      obyte_q <= obyte_d;
      ouser_q <= ouser_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

>>> sv/url_percent_decode_utf8_check_unit.sv
// Takes one url character per word and returns decoded bytes: '+' becomes a space,
// %XX becomes a byte that must be printable ascii or part of a complete percent-encoded
// utf-8 character, other non-zero characters pass unchanged; all output is checked as utf-8.
// A word carries a byte, a final-character result, or both; on the final character
// decode_ok tells whether the whole url was clean. Sustained rate is one character per
// cycle while the output is not stalled; each character passes through the queue and
// then the output register. A queue of QUEUE_DEPTH words lets input and output stall
// independently.
// depends on upd_pkg, upd_front, upd_fifo, upd_back
`default_nettype none

module url_percent_decode_utf8_check_unit import upd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // char_in
  input  wire logic       s_axis_tlast,   // last_char
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [1:0]      m_axis_tuser,   // byte_valid, decode_ok
  output logic            m_axis_tlast    // done_res
);

  logic      q_full, q_push, q_pop, q_valid;
  upd_item_t push_item, pop_item;

  upd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  upd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .valid_o     (q_valid)
  );

  upd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> sv/upd_checker.sv
// port-level checks for the url decoder output stream, bound to the top level
// depends on url_percent_decode_utf8_check_unit
`default_nettype none

module upd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("decode_ok without done");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00 && m_axis_tlast)
    else $error("word without byte must be a final result with zero data");

  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 8'h00)
    else $error("zero byte emitted");

endmodule

bind url_percent_decode_utf8_check_unit upd_checker u_upd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
